[rtl/global_sequence_alignment_macros.svh]
// Assertion helpers shared by the alignment RTL.
// Both expect clk and rst_n in scope in the module that uses them.
`ifndef GLOBAL_SEQUENCE_ALIGNMENT_MACROS_SVH
`define GLOBAL_SEQUENCE_ALIGNMENT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gsa_pkg.sv]
package gsa_pkg;

  // Longest sequence that is kept; the score matrix is one larger each way.
  localparam int MAX_LEN = 32;
  localparam int LEN_W   = 6;
  localparam int IDX_W   = 5;
  localparam int SCORE_W = 12;
  localparam int CNT_W   = 7;

  localparam logic [7:0] GAP_MARK = 8'h2D;

  // Alignment column kinds, which are also the traceback directions.
  localparam logic [1:0] KIND_PAIR  = 2'd0;
  localparam logic [1:0] KIND_GAP_Y = 2'd1;
  localparam logic [1:0] KIND_GAP_X = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MATCH    = 2'd0;
  localparam logic [1:0] CFG_MISMATCH = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;

  // One beat of the score wavefront passed from cell to cell.
  typedef struct packed {
    logic             v;
    logic [7:0]       x;
    logic [LEN_W-1:0] row;
    logic [11:0]      h;
    logic [11:0]      hp;
  } flow_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic             clr;
    logic             y_we;
    logic [IDX_W-1:0] y_idx;
    logic [7:0]       y_data;
    logic [IDX_W-1:0] dir_raddr;
    logic [3:0]       match;
    logic [4:0]       mism;
    logic [4:0]       gap;
  } cell_ctl_t;

  // Adds a small signed step to a score and clamps to the 12-bit range.
  function automatic logic [11:0] add_sat(input logic [11:0] a, input logic [12:0] b);
    logic signed [12:0] s;
    begin
      s = $signed({a[11], a}) + $signed(b);
      if (s < -13'sd2048) add_sat = 12'h800;
      else if (s > 13'sd2047) add_sat = 12'h7FF;
      else add_sat = s[11:0];
    end
  endfunction

  function automatic logic [12:0] sext5(input logic [4:0] v);
    sext5 = {{8{v[4]}}, v};
  endfunction

endpackage

[rtl/gsa_ifs.sv]
interface gsa_in_if;
  logic       valid;
  logic       ready;
  logic       which_seq;
  logic       has_symbol;
  logic [7:0] symbol;
  logic       last_of_seq;
  modport source(output valid, which_seq, has_symbol, symbol, last_of_seq, input ready);
  modport sink(input valid, which_seq, has_symbol, symbol, last_of_seq, output ready);
endinterface

interface gsa_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        x_symbol;
  logic [7:0]        y_symbol;
  logic [1:0]        column_kind;
  logic signed [11:0] score;
  logic              overflow;
  logic              last;
  modport source(output valid, x_symbol, y_symbol, column_kind, score, overflow, last,
                 input ready);
  modport sink(input valid, x_symbol, y_symbol, column_kind, score, overflow, last,
               output ready);
endinterface

[rtl/global_sequence_alignment.sv]
// Global alignment of two byte sequences with a linear gap cost.
// in_ch carries one beat per symbol: which_seq picks the sequence, has_symbol
// marks a real symbol and last_of_seq ends that sequence. Symbols beyond 32
// are dropped and reported through overflow. Loading takes one beat per cycle.
// Once both sequences have ended, the beat that ended the second one starts
// the work: rows of the score matrix flow down a chain of 32 cells, one cell
// per second-sequence column. The traceback walks back from the corner, reading
// direction memory at each step off the borders; once a column is taken, the
// next is read from the path memory into the output register. in_ch is not
// ready from the ending beat until the final column is taken. out_ch holds
// each column in an output register until it is accepted, so a stalled receiver
// simply pauses the emission. Columns come in forward order, each with the
// final score; last marks the final one. An empty pair yields a single column
// of kind 3. cfg_we writes register cfg_idx (0 match, 1 mismatch, 2 gap) with
// cfg_data; the user must use it only while the block is idle, which the block
// does not enforce. Reset clears the lengths, flags and state machine and
// restores the default scores of 1, -1 and -1; no clearing pass is needed.
`include "global_sequence_alignment_macros.svh"

module global_sequence_alignment import gsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gsa_in_if.sink     in_ch,
  gsa_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [4:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_FILL, ST_TRACE_RD, ST_TRACE_SEL, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
  } state_t;

  state_t           state_r;
  logic [3:0]       match_r;
  logic [4:0]       mism_r, gap_r;
  logic [LEN_W-1:0] len1_r, len2_r;
  logic [1:0]       done_r;
  logic             ovf_r;
  logic [LEN_W-1:0] feed_r, pend_row_r;
  logic             pend_v_r;
  flow_t            src_r;
  logic [11:0]      score_r;
  logic [LEN_W-1:0] tr_i_r, tr_j_r, ei_r, ej_r;
  logic [CNT_W-1:0] cnt_r;
  logic [LEN_W-1:0] ptr_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_x_r, out_y_r;
  logic [1:0]       out_kind_r;

  logic             acc, skip, go_fill, room;
  logic [1:0]       seq_bit, done_new;
  logic             x_we;
  logic [IDX_W-1:0] x_raddr;
  logic [7:0]       x_rdata;
  logic             stk_we;
  logic [1:0]       stk_wdata, stk_rdata;
  cell_ctl_t        ctl;
  flow_t            col [MAX_LEN+1];
  logic [7:0]       y_col [MAX_LEN];
  logic [1:0]       dir_col [MAX_LEN];
  flow_t            col_m;
  logic [1:0]       kind;

  // Input beat decode.
  always_comb begin
    acc      = in_ch.valid && in_ch.ready;
    seq_bit  = in_ch.which_seq ? 2'b10 : 2'b01;
    skip     = (done_r & seq_bit) != 2'b00;
    room     = in_ch.which_seq ? (len2_r < LEN_W'(MAX_LEN)) : (len1_r < LEN_W'(MAX_LEN));
    done_new = done_r | (in_ch.last_of_seq ? seq_bit : 2'b00);
    go_fill  = acc && !skip && done_new == 2'b11;
    x_we     = acc && !skip && in_ch.has_symbol && !in_ch.which_seq && room;
  end

  assign in_ch.ready = (state_r == ST_LOAD);

  // Controls shared by the cells.
  always_comb begin
    ctl.clr       = go_fill;
    ctl.y_we      = acc && !skip && in_ch.has_symbol && in_ch.which_seq && room;
    ctl.y_idx     = len2_r[IDX_W-1:0];
    ctl.y_data    = in_ch.symbol;
    ctl.dir_raddr = IDX_W'(tr_i_r - LEN_W'(1));
    ctl.match     = match_r;
    ctl.mism      = mism_r;
    ctl.gap       = gap_r;
  end

  // First-sequence read address: row feed during the fill, column during emission.
  assign x_raddr = (state_r == ST_FILL) ? IDX_W'(feed_r - LEN_W'(1)) : ei_r[IDX_W-1:0];

  gsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (len1_r[IDX_W-1:0]),
    .wdata (in_ch.symbol),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  // Column zero of the wavefront is the left border.
  assign col[0] = src_r;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    gsa_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx    (IDX_W'(k)),
      .ctl    (ctl),
      .din    (col[k]),
      .dout   (col[k+1]),
      .y_sym  (y_col[k]),
      .dir_rd (dir_col[k])
    );
  end

  assign col_m = col[len2_r];

  // Traceback step: direction from the cell column, or forced along a border.
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = KIND_PAIR;
    if (state_r == ST_TRACE_SEL) begin
      stk_we    = 1'b1;
      stk_wdata = dir_col[IDX_W'(tr_j_r - LEN_W'(1))];
    end else if (state_r == ST_TRACE_RD && (tr_i_r == '0 || tr_j_r == '0) &&
                 !(tr_i_r == '0 && tr_j_r == '0)) begin
      stk_we    = 1'b1;
      stk_wdata = (tr_j_r == '0) ? KIND_GAP_Y : KIND_GAP_X;
    end
  end

  gsa_ram #(.WIDTH(2), .DEPTH(2 * MAX_LEN)) u_path_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_r[LEN_W-1:0]),
    .wdata (stk_wdata),
    .raddr (ptr_r),
    .rdata (stk_rdata)
  );

  assign kind = stk_rdata;

  // Control state, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      match_r     <= 4'd1;
      mism_r      <= 5'h1F;
      gap_r       <= 5'h1F;
      len1_r      <= '0;
      len2_r      <= '0;
      done_r      <= 2'b00;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      src_r.v     <= 1'b0;
      out_valid_r <= 1'b0;
      feed_r      <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MATCH:    match_r <= cfg_data[3:0];
          CFG_MISMATCH: mism_r  <= cfg_data;
          CFG_GAP:      gap_r   <= cfg_data;
          default:      ;
        endcase
      end

      // Row feed into the border source, one row per cycle.
      pend_v_r   <= (state_r == ST_FILL) && (feed_r <= len1_r);
      pend_row_r <= feed_r;
      src_r.v    <= pend_v_r;
      if (pend_v_r) begin
        src_r.x   <= x_rdata;
        src_r.row <= pend_row_r;
        src_r.hp  <= src_r.h;
        src_r.h   <= (pend_row_r == '0) ? 12'd0 : add_sat(src_r.h, sext5(gap_r));
      end

      case (state_r)
        ST_LOAD: begin
          if (acc && !skip) begin
            if (in_ch.has_symbol) begin
              if (!room) begin
                ovf_r <= 1'b1;
              end else if (in_ch.which_seq) begin
                len2_r <= len2_r + LEN_W'(1);
              end else begin
                len1_r <= len1_r + LEN_W'(1);
              end
            end
            done_r <= done_new;
            if (go_fill) begin
              state_r <= ST_FILL;
              feed_r  <= '0;
            end
          end
        end
        ST_FILL: begin
          if (feed_r <= len1_r) begin
            feed_r <= feed_r + LEN_W'(1);
          end
          if (col_m.v && col_m.row == len1_r) begin
            score_r <= col_m.h;
            tr_i_r  <= len1_r;
            tr_j_r  <= len2_r;
            cnt_r   <= '0;
            state_r <= ST_TRACE_RD;
          end
        end
        ST_TRACE_RD: begin
          if (tr_i_r == '0 && tr_j_r == '0) begin
            ei_r <= '0;
            ej_r <= '0;
            ptr_r <= LEN_W'(cnt_r - CNT_W'(1));
            if (cnt_r == '0) begin
              out_x_r     <= GAP_MARK;
              out_y_r     <= GAP_MARK;
              out_kind_r  <= KIND_EMPTY;
              out_last_r  <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= ST_EMIT_WAIT;
            end else begin
              state_r <= ST_EMIT_RD;
            end
          end else if (tr_i_r == '0) begin
            tr_j_r <= tr_j_r - LEN_W'(1);
            cnt_r  <= cnt_r + CNT_W'(1);
          end else if (tr_j_r == '0) begin
            tr_i_r <= tr_i_r - LEN_W'(1);
            cnt_r  <= cnt_r + CNT_W'(1);
          end else begin
            state_r <= ST_TRACE_SEL;
          end
        end
        ST_TRACE_SEL: begin
          if (stk_wdata != KIND_GAP_X) tr_i_r <= tr_i_r - LEN_W'(1);
          if (stk_wdata != KIND_GAP_Y) tr_j_r <= tr_j_r - LEN_W'(1);
          cnt_r   <= cnt_r + CNT_W'(1);
          state_r <= ST_TRACE_RD;
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          out_x_r     <= (kind != KIND_GAP_X) ? x_rdata : GAP_MARK;
          out_y_r     <= (kind != KIND_GAP_Y) ? y_col[ej_r[IDX_W-1:0]] : GAP_MARK;
          out_kind_r  <= kind;
          out_last_r  <= (ptr_r == '0);
          out_valid_r <= 1'b1;
          if (kind != KIND_GAP_X) ei_r <= ei_r + LEN_W'(1);
          if (kind != KIND_GAP_Y) ej_r <= ej_r + LEN_W'(1);
          state_r     <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              len1_r  <= '0;
              len2_r  <= '0;
              done_r  <= 2'b00;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              ptr_r   <= ptr_r - LEN_W'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // Result beat.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_symbol    = out_x_r;
  assign out_ch.y_symbol    = out_y_r;
  assign out_ch.column_kind = out_kind_r;
  assign out_ch.score       = $signed(score_r);
  assign out_ch.overflow    = ovf_r;
  assign out_ch.last        = out_last_r;

  // The path never leaves the matrix, and the final column pops the bottom entry.
  `GSA_ASSERT_IMP(a_trace_in_matrix, state_r == ST_TRACE_RD, tr_i_r <= len1_r && tr_j_r <= len2_r, "traceback outside matrix")
  `GSA_ASSERT_IMP(a_last_at_bottom, out_valid_r && out_last_r && out_kind_r != KIND_EMPTY, ptr_r == '0, "last column before path end")
  `GSA_ASSERT_NXT(a_no_load_while_busy, out_valid_r, !in_ch.ready || !out_valid_r, "input taken during emission")

endmodule

[rtl/gsa_ram.sv]
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/gsa_cell.sv]
module gsa_cell import gsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  flow_t            din,
  output flow_t            dout,
  output logic [7:0]       y_sym,
  output logic [1:0]       dir_rd
);

  logic [7:0]  y_r;
  flow_t       flow_r;
  logic [12:0] pair;
  logic [11:0] d_sc, u_sc, l_sc, best;
  logic [1:0]  dir;
  logic        dir_we;

  // The second-sequence symbol of this column is written while loading.
  always_ff @(posedge clk) begin
    if (ctl.y_we && ctl.y_idx == idx) begin
      y_r <= ctl.y_data;
    end
  end

  // Candidate scores: diagonal, from above (own last row) and from the left.
  always_comb begin
    pair = (din.x == y_r) ? {9'd0, ctl.match} : sext5(ctl.mism);
    d_sc = add_sat(din.hp, pair);
    u_sc = add_sat(flow_r.h, sext5(ctl.gap));
    l_sc = add_sat(din.h, sext5(ctl.gap));
    if ($signed(d_sc) >= $signed(u_sc) && $signed(d_sc) >= $signed(l_sc)) begin
      dir  = KIND_PAIR;
      best = d_sc;
    end else if ($signed(u_sc) >= $signed(l_sc)) begin
      dir  = KIND_GAP_Y;
      best = u_sc;
    end else begin
      dir  = KIND_GAP_X;
      best = l_sc;
    end
    dir_we = din.v && (din.row != '0);
  end

  // Wavefront register; the border row only takes the left neighbour plus a gap.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      flow_r.v <= 1'b0;
    end else begin
      flow_r.v <= din.v;
    end
    if (din.v) begin
      flow_r.x   <= din.x;
      flow_r.row <= din.row;
      flow_r.hp  <= flow_r.h;
      flow_r.h   <= (din.row == '0) ? l_sc : best;
    end
  end

  // Traceback directions of this column, one per matrix row.
  gsa_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (IDX_W'(din.row - LEN_W'(1))),
    .wdata (dir),
    .raddr (ctl.dir_raddr),
    .rdata (dir_rd)
  );

  assign dout  = flow_r;
  assign y_sym = y_r;

endmodule

[verif/gsa_checker.sv]
// Watches both channels of the alignment block, predicts every column from the
// accepted input beats and compares each accepted output beat with the oldest
// predicted column.
module gsa_checker import gsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gsa_in_if          in_mon,
  gsa_out_if         out_mon,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         cols_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [1:0]  kind;
    logic [11:0] score;
    logic        ovf;
    logic        last;
  } column_t;

  column_t col_q[$];

  // Shadow copy of the scoring registers.
  int w_match;
  int w_mism;
  int w_gap;

  // Shadow copy of the loaded sequences.
  logic [7:0] x_seq[MAX_LEN];
  logic [7:0] y_seq[MAX_LEN];
  int         x_len;
  int         y_len;
  bit [1:0]   ended;
  bit         dropped;

  initial fail_count = 0;
  initial cols_pending = 0;

  function automatic int clamp12(input int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int pair_gain(input int i, input int j);
    return (x_seq[i-1] == y_seq[j-1]) ? w_match : w_mism;
  endfunction

  // Fills the score matrix, traces back from the corner and queues the
  // columns in forward order.
  function automatic void align_pair();
    int h[0:MAX_LEN][0:MAX_LEN];
    logic [1:0] dirs[2*MAX_LEN];
    int i, j, cnt, d, u, l, best, fs, xi, yi;
    column_t c;
    h[0][0] = 0;
    for (i = 1; i <= x_len; i++) h[i][0] = clamp12(h[i-1][0] + w_gap);
    for (j = 1; j <= y_len; j++) h[0][j] = clamp12(h[0][j-1] + w_gap);
    for (i = 1; i <= x_len; i++) begin
      for (j = 1; j <= y_len; j++) begin
        d = clamp12(h[i-1][j-1] + pair_gain(i, j));
        u = clamp12(h[i-1][j] + w_gap);
        l = clamp12(h[i][j-1] + w_gap);
        best = d;
        if (u > best) best = u;
        if (l > best) best = l;
        h[i][j] = best;
      end
    end
    fs = h[x_len][y_len];
    i = x_len;
    j = y_len;
    cnt = 0;
    while ((i > 0 || j > 0) && cnt < 2 * MAX_LEN) begin
      if (i > 0 && j > 0 && h[i][j] == clamp12(h[i-1][j-1] + pair_gain(i, j))) begin
        dirs[cnt] = KIND_PAIR;
        i--;
        j--;
      end else if (i > 0 && (j == 0 || h[i][j] == clamp12(h[i-1][j] + w_gap))) begin
        dirs[cnt] = KIND_GAP_Y;
        i--;
      end else begin
        dirs[cnt] = KIND_GAP_X;
        j--;
      end
      cnt++;
    end
    c.score = fs[11:0];
    c.ovf = dropped;
    if (cnt == 0) begin
      c.x = GAP_MARK;
      c.y = GAP_MARK;
      c.kind = KIND_EMPTY;
      c.last = 1'b1;
      col_q.push_back(c);
      return;
    end
    xi = 0;
    yi = 0;
    for (int k = 0; k < cnt; k++) begin
      c.kind = dirs[cnt-1-k];
      c.x = (c.kind != KIND_GAP_X) ? x_seq[xi] : GAP_MARK;
      c.y = (c.kind != KIND_GAP_Y) ? y_seq[yi] : GAP_MARK;
      if (c.kind != KIND_GAP_X) xi++;
      if (c.kind != KIND_GAP_Y) yi++;
      c.last = (k + 1 == cnt);
      col_q.push_back(c);
    end
  endfunction

  // Applies one accepted input beat to the shadow state.
  function automatic void load_beat(input logic w, input logic has, input logic [7:0] s,
                                    input logic lst);
    if (ended[w]) return;
    if (has) begin
      if (w == 1'b0) begin
        if (x_len < MAX_LEN) x_seq[x_len++] = s;
        else dropped = 1'b1;
      end else begin
        if (y_len < MAX_LEN) y_seq[y_len++] = s;
        else dropped = 1'b1;
      end
    end
    if (lst) ended[w] = 1'b1;
    if (ended != 2'b11) return;
    align_pair();
    x_len = 0;
    y_len = 0;
    ended = 2'b00;
    dropped = 1'b0;
  endfunction

  task automatic report_bad(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    column_t e;
    if (!rst_n) begin
      w_match = 1;
      w_mism = -1;
      w_gap = -1;
      x_len = 0;
      y_len = 0;
      ended = 2'b00;
      dropped = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MATCH:    w_match = int'(cfg_data[3:0]);
          CFG_MISMATCH: w_mism = int'($signed(cfg_data));
          CFG_GAP:      w_gap = int'($signed(cfg_data));
          default: ;
        endcase
      end
      // Output beats are compared before the input beat of the same edge is
      // applied, since a pair cannot yield a column on its own ending beat.
      if (out_mon.valid && out_mon.ready) begin
        if (col_q.size() == 0) begin
          report_bad($sformatf("unexpected column x=%h y=%h kind=%0d",
                               out_mon.x_symbol, out_mon.y_symbol, out_mon.column_kind));
        end else begin
          e = col_q.pop_front();
          if (out_mon.x_symbol !== e.x || out_mon.y_symbol !== e.y ||
              out_mon.column_kind !== e.kind || out_mon.score !== e.score ||
              out_mon.overflow !== e.ovf || out_mon.last !== e.last)
            report_bad($sformatf(
              "column got x=%h y=%h kind=%0d score=%h ovf=%b last=%b, want %h %h %0d %h %b %b",
              out_mon.x_symbol, out_mon.y_symbol, out_mon.column_kind, out_mon.score,
              out_mon.overflow, out_mon.last, e.x, e.y, e.kind, e.score, e.ovf, e.last));
        end
      end
      if (in_mon.valid && in_mon.ready)
        load_beat(in_mon.which_seq, in_mon.has_symbol, in_mon.symbol, in_mon.last_of_seq);
    end
    cols_pending = col_q.size();
  end

endmodule

[verif/global_sequence_alignment_tb.sv]
// Drives sequence pairs into the alignment block under several score settings
// and gives the verdict from the checker's failure count.
module global_sequence_alignment_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit       w;
    bit       has;
    bit [7:0] s;
    bit       lst;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [4:0] cfg_data;
  int         fail_count;
  int         cols_pending;
  int         burst_left = 0;
  int         beats_sent = 0;
  int         idle_cycles = 0;
  bit         hold_go = 1'b0;

  gsa_in_if  in_bus();
  gsa_out_if out_bus();

  global_sequence_alignment i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  gsa_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .cols_pending (cols_pending)
  );

  always #5 clk = ~clk;

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: a changing stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 1) == 1);
        default: out_bus.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Offers one beat and returns at the edge where it is taken. Bursts of
  // back-to-back beats alternate with random gaps.
  task automatic put_beat(input beat_t b);
    int gap;
    logic rdy;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.which_seq   <= b.w;
    in_bus.has_symbol  <= b.has;
    in_bus.symbol      <= b.s;
    in_bus.last_of_seq <= b.lst;
    do begin
      @(negedge clk);
      rdy = in_bus.ready;
      @(posedge clk);
    end while (!rdy);
    beats_sent++;
  endtask

  task automatic put_fields(input bit w, input bit has, input bit [7:0] s, input bit lst);
    beat_t b;
    b.w = w;
    b.has = has;
    b.s = s;
    b.lst = lst;
    put_beat(b);
  endtask

  // Waits until every predicted column has come out, then lets the block
  // settle and writes all three scoring registers. The first wait lets the
  // checker queue the columns of a pair ended by the last beat taken.
  task automatic set_scores(input bit [3:0] m, input bit [4:0] mm, input bit [4:0] g);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (cols_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MATCH;
    cfg_data <= {1'b0, m};
    @(posedge clk);
    cfg_idx <= CFG_MISMATCH;
    cfg_data <= mm;
    @(posedge clk);
    cfg_idx <= CFG_GAP;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [7:0] pick_symbol(input bit narrow, input bit [7:0] base);
    return narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  // One pair of sequences with interleaved beats; optional noise beats are
  // empty non-final markers and beats aimed at a sequence that has ended.
  task automatic send_pair(input int n, input int m, input bit noisy);
    beat_t xq[$];
    beat_t yq[$];
    beat_t b;
    bit narrow;
    bit [7:0] base;
    bit split_end;
    narrow = ($urandom_range(0, 3) != 0);
    base = 8'($urandom_range(0, 255));
    for (int k = 0; k < 2; k++) begin
      int len;
      len = (k == 0) ? n : m;
      split_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int e = 0; e < len; e++) begin
        b.w = k[0];
        b.has = 1'b1;
        b.s = pick_symbol(narrow, base);
        b.lst = !split_end && (e == len - 1);
        if (k == 0) xq.push_back(b);
        else yq.push_back(b);
      end
      if (split_end) begin
        b.w = k[0];
        b.has = 1'b0;
        b.s = 8'($urandom_range(0, 255));
        b.lst = 1'b1;
        if (k == 0) xq.push_back(b);
        else yq.push_back(b);
      end
    end
    while (xq.size() != 0 || yq.size() != 0) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        b.w = $urandom_range(0, 1);
        b.has = 1'b0;
        b.s = 8'($urandom_range(0, 255));
        b.lst = 1'b0;
        if ((b.w == 1'b0 && xq.size() != 0) || (b.w == 1'b1 && yq.size() != 0))
          put_beat(b);
      end
      if (noisy && $urandom_range(0, 7) == 0 && (xq.size() == 0) != (yq.size() == 0)) begin
        // A beat for the sequence that has already ended is ignored.
        b.w = (xq.size() == 0) ? 1'b0 : 1'b1;
        b.has = $urandom_range(0, 1);
        b.s = 8'($urandom_range(0, 255));
        b.lst = $urandom_range(0, 1);
        put_beat(b);
      end
      if (yq.size() == 0 || (xq.size() != 0 && $urandom_range(0, 1) == 0))
        put_beat(xq.pop_front());
      else
        put_beat(yq.pop_front());
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(30, 36);
  endfunction

  task automatic random_pairs(input int quota);
    int goal;
    goal = beats_sent + quota;
    while (beats_sent < goal)
      send_pair(pick_len(), pick_len(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MATCH;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.which_seq = 1'b0;
    in_bus.has_symbol = 1'b0;
    in_bus.symbol = '0;
    in_bus.last_of_seq = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset scores.
    // Both sequences empty.
    put_fields(1'b0, 1'b0, 8'h00, 1'b1);
    put_fields(1'b1, 1'b0, 8'hFF, 1'b1);
    // One symbol each, equal extremes, ended on the symbol beat.
    put_fields(1'b1, 1'b1, 8'hFF, 1'b1);
    put_fields(1'b0, 1'b1, 8'hFF, 1'b1);
    // A mismatch against the gap mark byte.
    put_fields(1'b0, 1'b1, 8'h00, 1'b1);
    put_fields(1'b1, 1'b1, 8'h2D, 1'b1);
    // Beats for an ended sequence are ignored; an empty marker without end.
    put_fields(1'b0, 1'b1, 8'h41, 1'b0);
    put_fields(1'b0, 1'b0, 8'h55, 1'b0);
    put_fields(1'b0, 1'b1, 8'hAA, 1'b1);
    put_fields(1'b0, 1'b1, 8'h12, 1'b1);
    put_fields(1'b1, 1'b1, 8'hAA, 1'b0);
    put_fields(1'b1, 1'b1, 8'h41, 1'b0);
    put_fields(1'b1, 1'b0, 8'h00, 1'b1);
    // First sequence only, second empty: a run of gaps in the second.
    put_fields(1'b0, 1'b1, 8'h01, 1'b0);
    put_fields(1'b0, 1'b1, 8'h80, 1'b1);
    put_fields(1'b1, 1'b0, 8'h00, 1'b1);

    random_pairs(60);

    // Extreme scores, with the receiver held off while beats keep coming.
    set_scores(4'd15, 5'b10000, 5'b10000);
    hold_go = 1'b1;
    random_pairs(80);

    set_scores(4'd0, 5'b01111, 5'b00000);
    random_pairs(60);

    set_scores(4'd0, 5'b10000, 5'b00000);
    random_pairs(50);

    set_scores(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
               5'(-$urandom_range(0, 16)));
    random_pairs(60);

    set_scores(4'd15, 5'b01111, 5'b11111);
    random_pairs(50);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (cols_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && cols_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/gsa_pkg.sv
rtl/gsa_ifs.sv
rtl/gsa_ram.sv
rtl/gsa_cell.sv
rtl/global_sequence_alignment.sv
verif/gsa_checker.sv
verif/global_sequence_alignment_tb.sv
